### hdl/dnt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dnt_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int NAME_BYTES_DEF = 8;
  localparam int NAME_W_MAX     = 64;
  localparam int SECTOR_W       = 16;
  localparam int SLOT_W         = 4;
  localparam int ACTION_W       = 3;
  localparam int QDEPTH         = 2;

  localparam logic [ACTION_W-1:0] ACT_LOOKUP     = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD_FILE   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_ADD_DIR    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_ADD_DOTS   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_REMOVE     = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_SECTOR_DIR = 3'd5;

  typedef enum logic [2:0] {
    OP_LOOKUP,
    OP_ADD,
    OP_DOTS,
    OP_REMOVE,
    OP_SECDIR,
    OP_NONE
  } op_t;

  typedef struct packed {
    logic [ACTION_W-1:0]   action;
    logic [NAME_W_MAX-1:0] name;
    logic [SECTOR_W-1:0]   sector;
    logic [SECTOR_W-1:0]   parent_sector;
  } req_t;

  typedef struct packed {
    logic                ok;
    logic [SLOT_W-1:0]   slot;
    logic [SECTOR_W-1:0] found_sector;
    logic                is_directory;
    logic                empty_res;
    logic                full_res;
  } rsp_t;

  // classified transaction handed from front to back
  typedef struct packed {
    op_t                   op;
    logic                  add_dir;
    logic [NAME_W_MAX-1:0] name;
    logic [SECTOR_W-1:0]   sector;
    logic [SECTOR_W-1:0]   parent_sector;
  } cmd_t;

  // keep bytes up to the first zero byte or nb bytes, clear the rest
  function automatic logic [NAME_W_MAX-1:0] trim_name(input logic [NAME_W_MAX-1:0] n,
                                                       input int nb);
    logic [NAME_W_MAX-1:0] r;
    logic                  stop;
    r    = '0;
    stop = 1'b0;
    for (int b = 0; b < NAME_W_MAX / 8; b++) begin
      if (b >= nb || n[8*b +: 8] == 8'h00) begin
        stop = 1'b1;
      end
      if (!stop) begin
        r[8*b +: 8] = n[8*b +: 8];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/dnt_front.sv
`timescale 1ns / 1ps
`default_nettype none

module dnt_front #(
  parameter int NAME_BYTES = dnt_pkg::NAME_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire dnt_pkg::req_t req,
  output logic               cmd_valid,
  input  wire logic          cmd_ready,
  output dnt_pkg::cmd_t      cmd
);

  localparam int QPTR_W = (dnt_pkg::QDEPTH > 1) ? $clog2(dnt_pkg::QDEPTH) : 1;
  localparam int QCNT_W = $clog2(dnt_pkg::QDEPTH + 1);

  dnt_pkg::cmd_t      cls;
  dnt_pkg::cmd_t      q_mem [dnt_pkg::QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  fill;
  logic               push;
  logic               pop;

  always_comb begin
    cls.add_dir       = (req.action == dnt_pkg::ACT_ADD_DIR);
    cls.name          = dnt_pkg::trim_name(req.name, NAME_BYTES);
    cls.sector        = req.sector;
    cls.parent_sector = req.parent_sector;
    case (req.action)
      dnt_pkg::ACT_LOOKUP:     cls.op = dnt_pkg::OP_LOOKUP;
      dnt_pkg::ACT_ADD_FILE:   cls.op = dnt_pkg::OP_ADD;
      dnt_pkg::ACT_ADD_DIR:    cls.op = dnt_pkg::OP_ADD;
      dnt_pkg::ACT_ADD_DOTS:   cls.op = dnt_pkg::OP_DOTS;
      dnt_pkg::ACT_REMOVE:     cls.op = dnt_pkg::OP_REMOVE;
      dnt_pkg::ACT_SECTOR_DIR: cls.op = dnt_pkg::OP_SECDIR;
      default:                 cls.op = dnt_pkg::OP_NONE;
    endcase
  end

  assign req_ready = (fill != QCNT_W'(dnt_pkg::QDEPTH));
  assign cmd_valid = (fill != '0);
  assign cmd       = q_mem[rd_ptr];
  assign push      = req_valid && req_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(dnt_pkg::QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(dnt_pkg::QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### hdl/dnt_back.sv
`timescale 1ns / 1ps
`default_nettype none

module dnt_back #(
  parameter int ENTRIES    = dnt_pkg::ENTRIES_DEF,
  parameter int NAME_BYTES = dnt_pkg::NAME_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire dnt_pkg::cmd_t cmd,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output dnt_pkg::rsp_t      rsp
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES - 1);
  localparam int NAME_W = 8 * NAME_BYTES;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [dnt_pkg::NAME_W_MAX-1:0] DOT_NAME =
    dnt_pkg::trim_name(64'h2E, NAME_BYTES);
  localparam logic [dnt_pkg::NAME_W_MAX-1:0] DOTDOT_NAME =
    dnt_pkg::trim_name(64'h2E2E, NAME_BYTES);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_FINISH = 6'b000100,
    S_DOT0   = 6'b001000,
    S_DOT1   = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  state_t                       state;
  dnt_pkg::cmd_t                cur;
  logic [ENTRIES-1:0]           in_use;
  logic [CNT_W-1:0]             cnt_used;

  // entry storage
  logic [NAME_W-1:0]            name_mem [ENTRIES];
  logic [dnt_pkg::SECTOR_W-1:0] sec_mem  [ENTRIES];
  logic                         dir_mem  [ENTRIES];

  logic                         mem_we;
  logic [IDX_W-1:0]             mem_waddr;
  logic [NAME_W-1:0]            mem_wname;
  logic [dnt_pkg::SECTOR_W-1:0] mem_wsec;
  logic                         mem_wdir;

  // scan pipeline
  logic [IDX_W-1:0]             scan_idx;
  logic                         issue_on;
  logic                         cmp_vld;
  logic                         cmp_used;
  logic [IDX_W-1:0]             cmp_idx;
  logic [NAME_W-1:0]            rd_name;
  logic [dnt_pkg::SECTOR_W-1:0] rd_sec;
  logic                         rd_dir;
  logic                         hit;

  logic                         found;
  logic [IDX_W-1:0]             found_idx;
  logic [dnt_pkg::SECTOR_W-1:0] found_sec;
  logic                         found_dir;
  logic                         free_any;
  logic [IDX_W-1:0]             free_idx;

  logic                         res_ok;
  logic [IDX_W-1:0]             res_idx;
  logic [dnt_pkg::SECTOR_W-1:0] res_fsec;
  logic                         res_dir;
  logic [7:0]                   res_idx_wide;

  logic                         add_do;
  logic                         remove_do;
  logic                         dots_free;
  logic                         rsp_load;

  assign cmd_ready    = (state == S_IDLE);
  assign add_do       = (cur.op == dnt_pkg::OP_ADD) && !found && free_any;
  assign remove_do    = (cur.op == dnt_pkg::OP_REMOVE) && found;
  assign dots_free    = !in_use[0] && !in_use[1];
  assign rsp_load     = (state == S_RESP) && (!rsp_valid || rsp_ready);
  assign res_idx_wide = 8'(res_idx);

  assign hit = cmp_used && ((cur.op == dnt_pkg::OP_SECDIR) ? (rd_sec == cur.sector)
                                                           : (rd_name == cur.name[NAME_W-1:0]));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = free_idx;
    mem_wname = cur.name[NAME_W-1:0];
    mem_wsec  = cur.sector;
    mem_wdir  = cur.add_dir;
    case (state)
      S_FINISH: begin
        mem_we = add_do;
      end
      S_DOT0: begin
        mem_we    = dots_free;
        mem_waddr = '0;
        mem_wname = DOT_NAME[NAME_W-1:0];
        mem_wdir  = 1'b1;
      end
      S_DOT1: begin
        mem_we    = 1'b1;
        mem_waddr = IDX_W'(1);
        mem_wname = DOTDOT_NAME[NAME_W-1:0];
        mem_wsec  = cur.parent_sector;
        mem_wdir  = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      name_mem[mem_waddr] <= mem_wname;
      sec_mem[mem_waddr]  <= mem_wsec;
      dir_mem[mem_waddr]  <= mem_wdir;
    end
    rd_name  <= name_mem[scan_idx];
    rd_sec   <= sec_mem[scan_idx];
    rd_dir   <= dir_mem[scan_idx];
    cmp_used <= in_use[scan_idx];
    cmp_idx  <= scan_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issue_on  <= 1'b0;
      cmp_vld   <= 1'b0;
      in_use    <= '0;
      cnt_used  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      cmp_vld <= (state == S_SCAN) && issue_on;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              dnt_pkg::OP_DOTS: state <= S_DOT0;
              dnt_pkg::OP_NONE: state <= S_RESP;
              default: begin
                state    <= S_SCAN;
                issue_on <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issue_on) begin
            if (scan_idx == LAST_IDX) begin
              issue_on <= 1'b0;
            end
          end else begin
            // last entry is being compared on this edge
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (add_do) begin
            in_use[free_idx] <= 1'b1;
            if (free_idx >= IDX_W'(2)) begin
              cnt_used <= cnt_used + CNT_W'(1);
            end
          end
          if (remove_do) begin
            in_use[found_idx] <= 1'b0;
            if (found_idx >= IDX_W'(2)) begin
              cnt_used <= cnt_used - CNT_W'(1);
            end
          end
          state <= S_RESP;
        end
        S_DOT0: begin
          if (dots_free) begin
            in_use[0] <= 1'b1;
            state     <= S_DOT1;
          end else begin
            state <= S_RESP;
          end
        end
        S_DOT1: begin
          in_use[1] <= 1'b1;
          state     <= S_RESP;
        end
        S_RESP: begin
          if (!rsp_valid || rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      cur      <= cmd;
      scan_idx <= '0;
      found    <= 1'b0;
      free_any <= 1'b0;
      res_ok   <= 1'b0;
      res_idx  <= '0;
      res_fsec <= '0;
      res_dir  <= 1'b0;
    end
    if (state == S_SCAN && issue_on && scan_idx != LAST_IDX) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    if (cmp_vld) begin
      if (hit && !found) begin
        found     <= 1'b1;
        found_idx <= cmp_idx;
        found_sec <= rd_sec;
        found_dir <= rd_dir;
      end
      if (!cmp_used && !free_any) begin
        free_any <= 1'b1;
        free_idx <= cmp_idx;
      end
    end
    if (state == S_FINISH) begin
      case (cur.op)
        dnt_pkg::OP_LOOKUP: begin
          res_ok <= found;
          if (found) begin
            res_idx  <= found_idx;
            res_fsec <= found_sec;
          end
        end
        dnt_pkg::OP_ADD: begin
          res_ok <= add_do;
          if (add_do) begin
            res_idx <= free_idx;
          end
        end
        dnt_pkg::OP_REMOVE: begin
          res_ok <= found;
          if (found) begin
            res_idx <= found_idx;
          end
        end
        dnt_pkg::OP_SECDIR: begin
          res_ok <= found;
          if (found) begin
            res_idx <= found_idx;
            res_dir <= found_dir;
          end
        end
        default: begin
          res_ok <= 1'b0;
        end
      endcase
    end
    if (state == S_DOT0 && dots_free) begin
      res_ok <= 1'b1;
    end
    if (rsp_load) begin
      rsp.ok           <= res_ok;
      rsp.slot         <= res_idx_wide[dnt_pkg::SLOT_W-1:0];
      rsp.found_sector <= res_fsec;
      rsp.is_directory <= res_dir;
      rsp.empty_res    <= (cnt_used == '0);
      rsp.full_res     <= (cnt_used == CNT_W'(ENTRIES - 2));
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt_used <= CNT_W'(ENTRIES - 2))
    else $error("used count beyond table size");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.ok) |-> (rsp.slot == '0 && rsp.found_sector == '0 && !rsp.is_directory))
    else $error("failed transaction carries nonzero fields");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.empty_res && rsp.full_res))
    else $error("empty and full both set");

  a_scan_tail: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && !issue_on) |-> cmp_vld)
    else $error("scan ended without last compare");

  a_dots_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_DOT1) |-> (in_use[0] && $past(state) == S_DOT0))
    else $error("dot-dot entry written without dot entry");

endmodule

`default_nettype wire

### hdl/directory_name_table_core.sv
// Directory name table: a fixed table of ENTRIES name entries (in-use mark,
// directory flag, header sector, name of NAME_BYTES bytes).
// Request channel req_valid/req_ready/req carries action, name, sector and
// parent_sector; response channel rsp_valid/rsp_ready/rsp returns one
// transaction per request, in order.
// A front stage trims the name, decodes the action and parks the request in
// a two-deep queue; the back engine then scans the table one entry per cycle
// through the registered read port of the entry memory.
// Lookup, add, remove and sector query scan every entry in turn before they
// respond; add dots and unused actions skip the scan.
// One request is worked on at a time, so the engine takes no new request
// before its response is loaded; the queue keeps accepting up to two
// requests meanwhile.
// Reset (rst, synchronous) marks every slot free; no clearing pass is needed.
// A stalled receiver holds the response register; the engine finishes the
// next request and waits in front of the response register until it frees.
`timescale 1ns / 1ps
`default_nettype none

module directory_name_table_core #(
  parameter int ENTRIES    = dnt_pkg::ENTRIES_DEF,
  parameter int NAME_BYTES = dnt_pkg::NAME_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire dnt_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output dnt_pkg::rsp_t      rsp
);

  logic          cmd_valid;
  logic          cmd_ready;
  dnt_pkg::cmd_t cmd;

  dnt_front #(
    .NAME_BYTES (NAME_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  dnt_back #(
    .ENTRIES    (ENTRIES),
    .NAME_BYTES (NAME_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
